// ===== design/csq_pkg.sv =====
// Shared types, codes and the burst word expansion of the CPU step sequencer.
package csq_pkg;

  localparam int MAX_CLOCK_CHOICES = 8;
  localparam int QUEUE_AW = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  // Strobe bit masks; bit 0 is freeze word, bit 5 is store output.
  localparam logic [5:0] STB_FW  = 6'b000001;
  localparam logic [5:0] STB_FO  = 6'b000010;
  localparam logic [5:0] STB_HO  = 6'b000100;
  localparam logic [5:0] STB_IPC = 6'b001000;
  localparam logic [5:0] STB_SPC = 6'b010000;
  localparam logic [5:0] STB_SO  = 6'b100000;

  typedef enum logic [2:0] {
    KIND_TICK      = 3'd0,
    KIND_RESET     = 3'd1,
    KIND_DEBUG     = 3'd2,
    KIND_RUN_INSTR = 3'd3,
    KIND_RUN_STEP  = 3'd4,
    KIND_SEL_CLOCK = 3'd5,
    KIND_DISABLE   = 3'd6,
    KIND_BURST     = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_STEP  = 3'd1,
    MODE_INSTR = 3'd2,
    MODE_RUN   = 3'd3,
    MODE_TURBO = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_FETCH   = 3'd1,
    PH_EXEC    = 3'd2,
    PH_PCINC   = 3'd3,
    PH_PCSTORE = 3'd4,
    PH_PAUSE   = 3'd5,
    PH_STORE   = 3'd6,
    PH_RESET   = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    REG_ENABLED = 2'd0,
    REG_COUNT   = 2'd1,
    REG_SKIP    = 2'd2
  } reg_idx_t;

  // One queue entry: a plain snapshot, or the start state of a turbo burst.
  typedef struct packed {
    logic       burst;
    logic [5:0] strobes;
    logic       tick;
    mode_t      mode;
    phase_t     phase;
    logic       brk;
    logic       skip_brk;
  } csq_desc_t;

  typedef struct packed {
    logic [5:0] strobes;
    logic       tick;
    mode_t      mode;
    phase_t     phase;
    logic       last;
  } csq_word_t;

  typedef struct packed {
    logic full;
    logic avail;
  } csq_qstat_t;

  // Word number step of a turbo burst that starts from the state in d.
  function automatic csq_word_t csq_burst_word(csq_desc_t d, logic [2:0] step);
    csq_word_t  w;
    logic [5:0] s;
    s = d.strobes;
    w.tick = d.tick;
    w.mode = d.mode;
    w.last = 1'b0;
    case (step)
      3'd0: begin
        w.strobes = (s & (STB_FO | STB_HO | STB_IPC | STB_SPC)) | STB_FW;
        w.phase = PH_FETCH;
      end
      3'd1: begin
        w.strobes = (s & (STB_HO | STB_IPC | STB_SPC)) | STB_FO;
        w.phase = PH_EXEC;
      end
      3'd2: begin
        w.strobes = (s & STB_SPC) | STB_HO | STB_IPC;
        w.phase = PH_PCINC;
      end
      3'd3: begin
        w.strobes = STB_IPC | STB_SPC;
        w.phase = PH_PCSTORE;
      end
      3'd4: begin
        w.strobes = '0;
        w.phase = PH_PAUSE;
      end
      3'd5: begin
        w.strobes = d.skip_brk ? 6'b000000 : STB_SO;
        w.phase = PH_STORE;
      end
      default: begin
        w.strobes = '0;
        w.phase = PH_IDLE;
        w.last = 1'b1;
      end
    endcase
    // A break drops out of turbo from the fourth word on.
    if (d.brk && (step >= 3'd3)) begin
      w.mode = MODE_IDLE;
      w.tick = 1'b1;
    end
    return w;
  endfunction

endpackage

// ===== design/csq_front.sv =====
// Front end: configuration registers, sequencer state and classification of input words.
module csq_front
  import csq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  input  logic        push,
  input  logic [2:0]  in_kind,
  input  logic        in_break_n,
  input  logic [2:0]  in_clock_index,
  input  csq_qstat_t  qstat,
  output logic        enq,
  output csq_desc_t   enq_desc
);

  typedef struct packed {
    phase_t     phase;
    logic [5:0] strobes;
    mode_t      mode;
  } adv_t;

  logic       enabled_r, enabled_nxt;
  logic [3:0] count_r, count_nxt;
  logic       skip_r, skip_nxt;

  mode_t      mode_r, mode_nxt;
  phase_t     phase_r, phase_nxt;
  logic       rst_pend_r, rst_pend_nxt;
  logic [2:0] sel_r, sel_nxt;
  logic [5:0] stb_r, stb_nxt;
  logic       tick_r, tick_nxt;

  logic       cfg_wr;
  reg_idx_t   reg_idx;
  logic       brk;
  logic [3:0] eff_count;
  logic [3:0] new_eff;
  logic [2:0] sel_req;
  adv_t       adv;

  function automatic logic [3:0] clamp_count(logic [3:0] c);
    return (c > 4'(MAX_CLOCK_CHOICES)) ? 4'(MAX_CLOCK_CHOICES) : c;
  endfunction

  function automatic adv_t advance(phase_t ph, logic [5:0] s, mode_t m, logic b,
                                   logic skip);
    adv_t a;
    a.mode = m;
    case (ph)
      PH_IDLE: begin
        a.phase = PH_FETCH;
        a.strobes = (s & ~STB_SO) | STB_FW;
      end
      PH_FETCH: begin
        a.phase = PH_EXEC;
        a.strobes = (s & ~STB_FW) | STB_FO;
      end
      PH_EXEC: begin
        a.phase = PH_PCINC;
        a.strobes = (s & ~STB_FO) | STB_HO | STB_IPC;
      end
      PH_PCINC: begin
        a.phase = PH_PCSTORE;
        a.strobes = (s & ~STB_HO) | STB_SPC;
        if (b) begin
          a.mode = MODE_INSTR;
        end
      end
      PH_PCSTORE: begin
        a.phase = PH_PAUSE;
        a.strobes = s & ~(STB_IPC | STB_SPC);
      end
      PH_PAUSE: begin
        a.phase = PH_STORE;
        a.strobes = (skip && b) ? s : (s | STB_SO);
      end
      default: begin
        a.phase = PH_IDLE;
        a.strobes = '0;
      end
    endcase
    return a;
  endfunction

  assign enq     = push && !qstat.full;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign brk     = !in_break_n;
  assign eff_count = clamp_count(count_r);
  assign new_eff   = clamp_count(pwdata[3:0]);
  assign sel_req   = ({1'b0, in_clock_index} >= eff_count) ? 3'd0 : in_clock_index;
  assign adv       = advance(phase_r, stb_r, mode_r, brk, skip_r);

  always_comb begin
    case (reg_idx)
      REG_ENABLED: prdata = {31'd0, enabled_r};
      REG_COUNT:   prdata = {28'd0, count_r};
      REG_SKIP:    prdata = {31'd0, skip_r};
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    enabled_nxt  = enabled_r;
    count_nxt    = count_r;
    skip_nxt     = skip_r;
    mode_nxt     = mode_r;
    phase_nxt    = phase_r;
    rst_pend_nxt = rst_pend_r;
    sel_nxt      = sel_r;
    stb_nxt      = stb_r;
    tick_nxt     = tick_r;

    enq_desc.burst    = 1'b0;
    enq_desc.brk      = brk;
    enq_desc.skip_brk = skip_r && brk;

    if (enq) begin
      case (kind_t'(in_kind))
        KIND_TICK: begin
          if (tick_r) begin
            if (rst_pend_r) begin
              rst_pend_nxt = 1'b0;
              stb_nxt      = STB_SPC;
              phase_nxt    = PH_RESET;
              mode_nxt     = MODE_INSTR;
            end else begin
              case (mode_r)
                MODE_STEP: begin
                  phase_nxt = adv.phase;
                  stb_nxt   = adv.strobes;
                  mode_nxt  = MODE_IDLE;
                end
                MODE_INSTR: begin
                  phase_nxt = adv.phase;
                  stb_nxt   = adv.strobes;
                  mode_nxt  = (adv.phase == PH_IDLE) ? MODE_IDLE : adv.mode;
                end
                MODE_RUN: begin
                  if (phase_r == PH_IDLE && sel_r == 3'd0) begin
                    tick_nxt = 1'b0;
                    mode_nxt = MODE_TURBO;
                  end else begin
                    phase_nxt = adv.phase;
                    stb_nxt   = adv.strobes;
                    mode_nxt  = adv.mode;
                  end
                end
                MODE_TURBO: mode_nxt = MODE_IDLE;
                default: ;
              endcase
            end
          end
        end
        KIND_RESET: rst_pend_nxt = 1'b1;
        KIND_DEBUG: begin
          if (mode_r == MODE_RUN) begin
            mode_nxt = MODE_INSTR;
          end else if (mode_r == MODE_TURBO) begin
            mode_nxt = MODE_IDLE;
            tick_nxt = 1'b1;
          end else begin
            mode_nxt = MODE_RUN;
          end
        end
        KIND_RUN_INSTR: begin
          if (enabled_r) begin
            mode_nxt = MODE_INSTR;
            tick_nxt = 1'b1;
          end
        end
        KIND_RUN_STEP: begin
          if (enabled_r) begin
            mode_nxt = MODE_STEP;
            tick_nxt = 1'b1;
          end
        end
        KIND_SEL_CLOCK: begin
          sel_nxt = sel_req;
          if (sel_req != 3'd0 && mode_r == MODE_TURBO) begin
            mode_nxt = MODE_RUN;
            tick_nxt = 1'b1;
          end
        end
        KIND_DISABLE: begin
          rst_pend_nxt = 1'b1;
          stb_nxt      = '0;
          mode_nxt     = MODE_INSTR;
          phase_nxt    = PH_IDLE;
          tick_nxt     = 1'b1;
        end
        default: begin
          // A turbo burst always ends with every strobe low.
          if (mode_r == MODE_TURBO) begin
            enq_desc.burst = 1'b1;
            stb_nxt = '0;
            if (brk) begin
              mode_nxt = MODE_IDLE;
              tick_nxt = 1'b1;
            end
          end
        end
      endcase
    end

    if (cfg_wr) begin
      case (reg_idx)
        REG_ENABLED: enabled_nxt = pwdata[0];
        REG_COUNT: begin
          count_nxt = pwdata[3:0];
          if ({1'b0, sel_r} >= new_eff) begin
            sel_nxt = 3'd0;
          end
        end
        REG_SKIP: skip_nxt = pwdata[0];
        default: ;
      endcase
    end

    // Bursts carry the state they start from, plain words the state after the step.
    if (enq_desc.burst) begin
      enq_desc.strobes = stb_r;
      enq_desc.tick    = tick_r;
      enq_desc.mode    = mode_r;
      enq_desc.phase   = phase_r;
    end else begin
      enq_desc.strobes = stb_nxt;
      enq_desc.tick    = tick_nxt;
      enq_desc.mode    = mode_nxt;
      enq_desc.phase   = phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r  <= 1'b0;
      count_r    <= 4'd5;
      skip_r     <= 1'b0;
      mode_r     <= MODE_IDLE;
      phase_r    <= PH_IDLE;
      rst_pend_r <= 1'b1;
      sel_r      <= 3'd0;
      stb_r      <= '0;
      tick_r     <= 1'b1;
    end else begin
      enabled_r  <= enabled_nxt;
      count_r    <= count_nxt;
      skip_r     <= skip_nxt;
      mode_r     <= mode_nxt;
      phase_r    <= phase_nxt;
      rst_pend_r <= rst_pend_nxt;
      sel_r      <= sel_nxt;
      stb_r      <= stb_nxt;
      tick_r     <= tick_nxt;
    end
  end

endmodule

// ===== design/csq_queue.sv =====
// Short queue of classified words between the front end and the back end.
module csq_queue
  import csq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       enq,
  input  csq_desc_t  enq_desc,
  input  logic       deq,
  output csq_desc_t  head,
  output csq_qstat_t qstat
);

  csq_desc_t           mem_r [QUEUE_DEPTH];
  csq_desc_t           head_r;
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   cnt_r, cnt_nxt;

  assign head        = head_r;
  assign qstat.full  = (cnt_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign qstat.avail = (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = enq ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = deq ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QUEUE_AW+1)'(enq) - (QUEUE_AW+1)'(deq);
  end

  // The head register is loaded from the next read slot; a word written into
  // that slot in the same cycle is passed straight through.
  always_ff @(posedge clk) begin
    if (enq) begin
      mem_r[wr_ptr_r] <= enq_desc;
    end
    head_r <= (enq && (wr_ptr_r == rd_ptr_nxt)) ? enq_desc : mem_r[rd_ptr_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== design/csq_back.sv =====
// Back end: expands queue entries into result words and holds the output register.
module csq_back
  import csq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  csq_desc_t  head,
  input  csq_qstat_t qstat,
  output logic       deq,
  input  logic       pop,
  output logic       empty,
  output csq_word_t  out_word
);

  logic       out_valid_r, out_valid_nxt;
  csq_word_t  word_r, word_nxt;
  logic [2:0] step_r, step_nxt;
  logic       load;
  csq_word_t  gen;

  assign load     = !out_valid_r || pop;
  assign empty    = !out_valid_r;
  assign out_word = word_r;

  always_comb begin
    if (head.burst) begin
      gen = csq_burst_word(head, step_r);
    end else begin
      gen.strobes = head.strobes;
      gen.tick    = head.tick;
      gen.mode    = head.mode;
      gen.phase   = head.phase;
      gen.last    = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    word_nxt      = word_r;
    step_nxt      = step_r;
    deq           = 1'b0;
    if (load) begin
      out_valid_nxt = qstat.avail;
      if (qstat.avail) begin
        word_nxt = gen;
        // The entry leaves the queue with the last word it produces.
        if (gen.last) begin
          deq      = 1'b1;
          step_nxt = 3'd0;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= 3'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

endmodule

// ===== design/cpu_step_sequencer_top.sv =====
// Path: an accepted word goes through the queue head register into the output register, which holds it until popped.
// Throughput: one input word per cycle while the queue is not full; a turbo burst expands into
// seven result words in the back end, while the front end fills a four-entry queue.
// Reset: synchronous, active low; the state and control registers take their reset values
// at once, the data registers keep their contents, and both sides start empty.
module cpu_step_sequencer_top
  import csq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  in_kind,
  input  logic        in_break_n,
  input  logic [2:0]  in_clock_index,
  output logic        empty,
  input  logic        pop,
  output logic        out_freeze_word,
  output logic        out_freeze_opcode,
  output logic        out_hold_output,
  output logic        out_increment_pc,
  output logic        out_store_pc,
  output logic        out_store_output,
  output logic        out_tick_enabled,
  output logic [2:0]  out_run_mode,
  output logic [2:0]  out_step_phase,
  output logic        out_last
);

  csq_qstat_t qstat;
  csq_desc_t  enq_desc;
  csq_desc_t  head;
  csq_word_t  out_word;
  logic       enq;
  logic       deq;

  assign pready = 1'b1;
  assign full   = qstat.full;

  csq_front u_front (
    .clk,
    .rst_n,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .push,
    .in_kind,
    .in_break_n,
    .in_clock_index,
    .qstat,
    .enq,
    .enq_desc
  );

  csq_queue u_queue (
    .clk,
    .rst_n,
    .enq,
    .enq_desc,
    .deq,
    .head,
    .qstat
  );

  csq_back u_back (
    .clk,
    .rst_n,
    .head,
    .qstat,
    .deq,
    .pop,
    .empty,
    .out_word
  );

  assign out_freeze_word   = out_word.strobes[0];
  assign out_freeze_opcode = out_word.strobes[1];
  assign out_hold_output   = out_word.strobes[2];
  assign out_increment_pc  = out_word.strobes[3];
  assign out_store_pc      = out_word.strobes[4];
  assign out_store_output  = out_word.strobes[5];
  assign out_tick_enabled  = out_word.tick;
  assign out_run_mode      = out_word.mode;
  assign out_step_phase    = out_word.phase;
  assign out_last          = out_word.last;

`ifndef NO_ASSERTIONS
  // Within a burst each taken word is followed at once by the next phase; the store
  // phase is followed by the idle phase.
  a_burst_phase_order: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !out_last) |=>
      (!empty && out_step_phase == (($past(out_step_phase) == PH_STORE) ?
        3'(PH_IDLE) : 3'($past(out_step_phase) + 3'd1))))
    else $error("burst words out of phase order");

  // Only burst words are not last, and they never show the idle or reset phase.
  a_burst_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_last) |->
      (out_step_phase != PH_IDLE && out_step_phase != PH_RESET))
    else $error("non-final word with idle or reset phase");

  // The queue can only fill up while the output register holds a word.
  a_full_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.full |-> !empty)
    else $error("queue full while output register is empty");
`endif

endmodule
